@@ rtl/rnc_pkg.sv @@
// rnc_pkg: shared types and constants of the radius neighbour counter.
// Holds the request and response item layouts and the field widths.
// No dependencies.
`timescale 1ns / 1ps

package rnc_pkg;

   localparam int COORD_W           = 24;
   localparam int RADIUS_W          = 50;
   localparam int TOTAL_W           = 20;
   localparam int AVG_W             = 10;
   localparam int COUNT_W           = 11;
   localparam int ATOM_W            = 3 * COORD_W;
   localparam int MAX_ATOMS_DEFAULT = 1024;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(4000 * 4000);

   typedef struct packed {
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
      logic signed [COORD_W-1:0] z_coord;
      logic                      last_atom;
   } rnc_req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] neighbour_total;
      logic [AVG_W-1:0]   average_neighbours;
      logic [COUNT_W-1:0] atom_count;
      logic               overflowed;
   } rnc_rsp_type;

endpackage

@@ rtl/radius_neighbour_counter.sv @@
// radius_neighbour_counter: top level; front loader, job queue, pair-sweep back end.
// Loads one atom per cycle while busy is low; after the last atom of n stored atoms
// the result strobes once the single distance unit has visited every ordered pair
// and the average division is done. busy stays high meanwhile.
// The receiver cannot stall. Reset clears the atom count, drop flag and sets
// radius_squared to 16000000; the coordinate store is not cleared.
`timescale 1ns / 1ps

module radius_neighbour_counter #(
   parameter int MAX_ATOMS = rnc_pkg::MAX_ATOMS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  rnc_pkg::rnc_req_type          req_data,
   output logic                          rsp_valid,
   output rnc_pkg::rnc_rsp_type          rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rnc_pkg::RADIUS_W-1:0]  csr_wdata
);

   import rnc_pkg::*;

   localparam int IDX_W = $clog2(MAX_ATOMS);
   localparam int JOB_W = $clog2(MAX_ATOMS + 1) + 1;

   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic                accept;
   logic                wr_en, rd_en;
   logic [IDX_W-1:0]    wr_addr, rd_addr;
   logic [ATOM_W-1:0]   wr_data, rd_data;
   logic                job_push, job_pop, job_valid, back_busy;
   logic [JOB_W-1:0]    job_in_data, job_out_data;

   assign csr_ready = 1'b1;
   assign busy      = job_valid | back_busy;
   assign accept    = start & ~busy;
   assign radius_in = (csr_valid & csr_ready) ? csr_wdata : radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else begin
         radius_ff <= radius_in;
      end
   end

   rnc_front #(.MAX_ATOMS(MAX_ATOMS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .job_push (job_push),
      .job_data (job_in_data)
   );

   rnc_ram #(.WIDTH(ATOM_W), .DEPTH(MAX_ATOMS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rnc_job_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_jobs (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .pop       (job_pop),
      .not_empty (job_valid),
      .pop_data  (job_out_data)
   );

   rnc_back #(.MAX_ATOMS(MAX_ATOMS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .radius_squared (radius_ff),
      .job_valid      (job_valid),
      .job_data       (job_out_data),
      .job_pop        (job_pop),
      .back_busy      (back_busy),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

endmodule

@@ rtl/rnc_ram.sv @@
// rnc_ram: generic single-write, single-read RAM with registered read data.
// Parameterized by word width and depth. No dependencies.
`timescale 1ns / 1ps

module rnc_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ rtl/rnc_job_fifo.sv @@
// rnc_job_fifo: short queue of molecule jobs between front and back.
// Each entry carries the stored atom count and the drop flag. No dependencies.
`timescale 1ns / 1ps

module rnc_job_fifo #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   assign not_empty = (fill_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/rnc_front.sv @@
// rnc_front: accepts atom items, writes them to the coordinate store,
// tracks the stored count and drop flag, and queues a job on the last atom.
// Depends on rnc_pkg.
`timescale 1ns / 1ps

module rnc_front #(
   parameter int MAX_ATOMS = rnc_pkg::MAX_ATOMS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  rnc_pkg::rnc_req_type                req_data,
   output logic                                wr_en,
   output logic [$clog2(MAX_ATOMS)-1:0]        wr_addr,
   output logic [rnc_pkg::ATOM_W-1:0]          wr_data,
   output logic                                job_push,
   output logic [$clog2(MAX_ATOMS+1):0]        job_data
);

   import rnc_pkg::*;

   localparam int IDX_W = $clog2(MAX_ATOMS);
   localparam int CNT_W = $clog2(MAX_ATOMS + 1);

   logic [CNT_W-1:0] count_ff, count_in, count_after;
   logic             drop_ff, drop_in, drop_after;
   logic             room;

   always_comb begin
      room        = (count_ff < CNT_W'(MAX_ATOMS));
      count_after = room ? count_ff + CNT_W'(1) : count_ff;
      drop_after  = drop_ff | ~room;
      wr_en       = accept & room;
      wr_addr     = count_ff[IDX_W-1:0];
      wr_data     = {req_data.x_coord, req_data.y_coord, req_data.z_coord};
      job_push    = accept & req_data.last_atom;
      job_data    = {drop_after, count_after};
      count_in    = count_ff;
      drop_in     = drop_ff;
      if (accept) begin
         count_in = req_data.last_atom ? '0 : count_after;
         drop_in  = req_data.last_atom ? 1'b0 : drop_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

@@ rtl/rnc_back.sv @@
// rnc_back: all-pairs distance sweep over the coordinate store, neighbour
// count accumulation, bit-serial average division and result strobe.
// Depends on rnc_pkg.
`timescale 1ns / 1ps

module rnc_back #(
   parameter int MAX_ATOMS = rnc_pkg::MAX_ATOMS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rnc_pkg::RADIUS_W-1:0]        radius_squared,
   input  logic                                job_valid,
   input  logic [$clog2(MAX_ATOMS+1):0]        job_data,
   output logic                                job_pop,
   output logic                                back_busy,
   output logic                                rd_en,
   output logic [$clog2(MAX_ATOMS)-1:0]        rd_addr,
   input  logic [rnc_pkg::ATOM_W-1:0]          rd_data,
   output logic                                rsp_valid,
   output rnc_pkg::rnc_rsp_type                rsp_data
);

   import rnc_pkg::*;

   localparam int IDX_W  = $clog2(MAX_ATOMS);
   localparam int CNT_W  = $clog2(MAX_ATOMS + 1);
   localparam int TOT_W  = 2 * CNT_W;
   localparam int STEP_W = $clog2(TOT_W);
   localparam int SQ_W   = 2 * COORD_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOADI = 3'd1;
   localparam logic [2:0] ST_WAITI = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              drop_ff, drop_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [ATOM_W-1:0] atom_i_ff, atom_i_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [TOT_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic              p0_valid_ff, p0_valid_in, p0_self_ff, p0_self_in;
   logic              s1_valid_ff, s1_self_ff;
   logic [COORD_W-1:0] s1_mx_ff, s1_my_ff, s1_mz_ff;
   logic              s2_use_ff;
   logic [SQ_W-1:0]   s2_sx_ff, s2_sy_ff, s2_sz_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   rnc_rsp_type       rsp_data_ff, rsp_data_in;

   logic [RADIUS_W-1:0] dist_sum;
   logic                i_last, j_last;
   logic [CNT_W:0]      rem_shift;
   logic                rem_ge;
   logic [TOT_W+TOTAL_W-1:0] total_wide;
   logic [TOT_W+AVG_W-1:0]   avg_wide;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   function automatic logic [COORD_W-1:0] mag_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      logic [COORD_W:0]        m;
      d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
      m = d[COORD_W] ? -d : d;
      return m[COORD_W-1:0];
   endfunction

   assign back_busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      i_last   = (CNT_W'(i_ff) == n_ff - CNT_W'(1));
      j_last   = (CNT_W'(j_ff) == n_ff - CNT_W'(1));
      dist_sum = RADIUS_W'(s2_sx_ff) + RADIUS_W'(s2_sy_ff) + RADIUS_W'(s2_sz_ff);

      rem_shift = {rem_ff, quo_ff[TOT_W-1]};
      rem_ge    = (rem_shift >= {1'b0, n_ff});

      state_in     = state_ff;
      n_in         = n_ff;
      drop_in      = drop_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      atom_i_in    = atom_i_ff;
      total_in     = total_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      p0_valid_in  = 1'b0;
      p0_self_in   = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      job_pop      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = j_ff;

      if (s2_use_ff && (dist_sum <= radius_squared)) begin
         total_in = total_ff + TOT_W'(1);
      end

      total_wide = '0;
      avg_wide   = '0;
      count_wide = '0;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               n_in     = job_data[CNT_W-1:0];
               drop_in  = job_data[CNT_W];
               i_in     = '0;
               total_in = '0;
               state_in = ST_LOADI;
            end
         end
         ST_LOADI: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff;
            state_in = ST_WAITI;
         end
         ST_WAITI: begin
            atom_i_in = rd_data;
            j_in      = '0;
            state_in  = ST_SWEEP;
         end
         ST_SWEEP: begin
            rd_en       = 1'b1;
            p0_valid_in = 1'b1;
            p0_self_in  = (j_ff == i_ff);
            if (j_last) begin
               if (i_last) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_LOADI;
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!p0_valid_ff && !s1_valid_ff && !s2_use_ff) begin
               quo_in   = total_ff;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? CNT_W'(rem_shift - {1'b0, n_ff}) : rem_shift[CNT_W-1:0];
            quo_in  = {quo_ff[TOT_W-2:0], rem_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(TOT_W - 1)) begin
               total_wide = (TOT_W + TOTAL_W)'(total_ff);
               avg_wide   = (TOT_W + AVG_W)'(quo_in);
               count_wide = (CNT_W + COUNT_W)'(n_ff);
               rsp_data_in.neighbour_total    = total_wide[TOTAL_W-1:0];
               rsp_data_in.average_neighbours = avg_wide[AVG_W-1:0];
               rsp_data_in.atom_count         = count_wide[COUNT_W-1:0];
               rsp_data_in.overflowed         = drop_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_use_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p0_valid_ff  <= p0_valid_in;
         s1_valid_ff  <= p0_valid_ff;
         s2_use_ff    <= s1_valid_ff & ~s1_self_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      drop_ff     <= drop_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      atom_i_ff   <= atom_i_in;
      total_ff    <= total_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      p0_self_ff  <= p0_self_in;
      s1_self_ff  <= p0_self_ff;
      s1_mx_ff    <= mag_diff(rd_data[3*COORD_W-1:2*COORD_W],
                              atom_i_ff[3*COORD_W-1:2*COORD_W]);
      s1_my_ff    <= mag_diff(rd_data[2*COORD_W-1:COORD_W],
                              atom_i_ff[2*COORD_W-1:COORD_W]);
      s1_mz_ff    <= mag_diff(rd_data[COORD_W-1:0], atom_i_ff[COORD_W-1:0]);
      s2_sx_ff    <= SQ_W'(s1_mx_ff) * SQ_W'(s1_mx_ff);
      s2_sy_ff    <= SQ_W'(s1_my_ff) * SQ_W'(s1_my_ff);
      s2_sz_ff    <= SQ_W'(s1_mz_ff) * SQ_W'(s1_mz_ff);
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ sim/tb_radius_neighbour_counter.sv @@
`timescale 1ns / 1ps
// tb_radius_neighbour_counter: self-checking bench for radius_neighbour_counter.
// Loads molecules over start/busy, predicts each neighbour count in a scoreboard
// class and checks every strobed result. Depends on rnc_pkg and the RTL.

module tb_radius_neighbour_counter;
   import rnc_pkg::*;

   localparam int MAX_ATOMS     = MAX_ATOMS_DEFAULT;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 580;
   localparam logic [RADIUS_W-1:0] RADIUS_MAX = {RADIUS_W{1'b1}};
   localparam logic [RADIUS_W-1:0] SPAN_SQ =
      RADIUS_W'(64'd3 * 64'd16777215 * 64'd16777215);
   localparam int COORD_MIN = -8388608;
   localparam int COORD_MAX = 8388607;

   class neighbour_count_book;
      longint      radius_sq;
      rnc_req_type molecule[$];
      bit          dropped;
      rnc_rsp_type expected_counts[$];
      int          errors;

      function new();
         radius_sq = longint'(RADIUS_RESET);
         dropped   = 1'b0;
         errors    = 0;
      endfunction

      function longint dist_sq(rnc_req_type a, rnc_req_type b);
         longint dx, dy, dz;
         dx = longint'($signed(a.x_coord)) - longint'($signed(b.x_coord));
         dy = longint'($signed(a.y_coord)) - longint'($signed(b.y_coord));
         dz = longint'($signed(a.z_coord)) - longint'($signed(b.z_coord));
         return dx * dx + dy * dy + dz * dz;
      endfunction

      function void add_atom(rnc_req_type atom);
         longint      total, n, avg;
         rnc_rsp_type want;
         if (molecule.size() < MAX_ATOMS)
            molecule.push_back(atom);
         else
            dropped = 1'b1;
         if (!atom.last_atom)
            return;
         n     = molecule.size();
         total = 0;
         for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
               if (dist_sq(molecule[i], molecule[j]) <= radius_sq)
                  total += 2;
         avg = (n != 0) ? total / n : 0;
         want.neighbour_total    = total[TOTAL_W-1:0];
         want.average_neighbours = avg[AVG_W-1:0];
         want.atom_count         = n[COUNT_W-1:0];
         want.overflowed         = dropped;
         expected_counts.push_back(want);
         molecule.delete();
         dropped = 1'b0;
      endfunction

      function void check_result(rnc_rsp_type got);
         rnc_rsp_type want;
         if (expected_counts.size() == 0) begin
            $error("result with no molecule pending: total %0d count %0d",
                   got.neighbour_total, got.atom_count);
            errors++;
            return;
         end
         want = expected_counts.pop_front();
         if (got.neighbour_total !== want.neighbour_total) begin
            $error("neighbour_total: expected %0d, got %0d",
                   want.neighbour_total, got.neighbour_total);
            errors++;
         end
         if (got.average_neighbours !== want.average_neighbours) begin
            $error("average_neighbours: expected %0d, got %0d",
                   want.average_neighbours, got.average_neighbours);
            errors++;
         end
         if (got.atom_count !== want.atom_count) begin
            $error("atom_count: expected %0d, got %0d", want.atom_count, got.atom_count);
            errors++;
         end
         if (got.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   rnc_req_type         req_data;
   logic                rsp_valid;
   rnc_rsp_type         rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [RADIUS_W-1:0] csr_wdata;

   neighbour_count_book book;
   int                  random_sent = 0;

   radius_neighbour_counter #(
      .MAX_ATOMS(MAX_ATOMS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            book.add_atom(req_data);
         if (rsp_valid)
            book.check_result(rsp_data);
         if (csr_valid && csr_ready)
            book.radius_sq = longint'(csr_wdata);
      end
   end

   function automatic rnc_req_type atom_of(input int x, input int y, input int z,
                                           input bit is_last);
      rnc_req_type atom;
      atom.x_coord   = COORD_W'(x);
      atom.y_coord   = COORD_W'(y);
      atom.z_coord   = COORD_W'(z);
      atom.last_atom = is_last;
      return atom;
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] centre,
                                                      input int spread);
      int off;
      case ($urandom_range(19))
         0: pick_coord = COORD_W'(COORD_MIN);
         1: pick_coord = COORD_W'(COORD_MAX);
         2: pick_coord = COORD_W'($urandom);
         default: begin
            off        = int'($urandom_range(0, (2 << spread) - 1)) - (1 << spread);
            pick_coord = centre + COORD_W'(off);
         end
      endcase
   endfunction

   task automatic send_atom(input rnc_req_type atom);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= atom;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_off();
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic idle_gap(input int idle_pct);
      while ($urandom_range(99) < idle_pct) hold_off();
   endtask

   task automatic wait_drained();
      hold_off();
      while (book.expected_counts.size() != 0) @(posedge clock);
   endtask

   task automatic quiesce();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_radius(input logic [RADIUS_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_molecule(input int idle_pct, input int scale);
      int                 n, spread;
      logic [COORD_W-1:0] cx, cy, cz;
      rnc_req_type        atom, prev;
      n      = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      spread = scale + int'($urandom_range(0, 3)) - 1;
      if (spread < 0)
         spread = 0;
      if (spread > COORD_W - 1)
         spread = COORD_W - 1;
      cx   = COORD_W'($urandom);
      cy   = COORD_W'($urandom);
      cz   = COORD_W'($urandom);
      atom = '0;
      prev = '0;
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(15) == 0) begin
            atom = prev;
         end else begin
            atom.x_coord = pick_coord(cx, spread);
            atom.y_coord = pick_coord(cy, spread);
            atom.z_coord = pick_coord(cz, spread);
         end
         atom.last_atom = (i == n - 1);
         idle_gap(idle_pct);
         send_atom(atom);
         prev = atom;
         random_sent++;
      end
   endtask

   initial begin
      logic [RADIUS_W-1:0] radius;
      int                  scale, target, idle_pct;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      book      = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // lone atom, then the reset radius right at and just past its edge
      send_atom(atom_of(0, 0, 0, 1'b1));
      send_atom(atom_of(0, 0, 0, 1'b0));
      send_atom(atom_of(4000, 0, 0, 1'b0));
      send_atom(atom_of(0, 0, 4001, 1'b1));
      quiesce();

      // zero radius: only coincident atoms count
      write_radius('0);
      send_atom(atom_of(5, -5, 7, 1'b0));
      send_atom(atom_of(5, -5, 7, 1'b0));
      send_atom(atom_of(1, 2, 3, 1'b1));
      quiesce();

      // corner to corner distance, exactly and one short
      write_radius(SPAN_SQ);
      send_atom(atom_of(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
      send_atom(atom_of(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
      quiesce();
      write_radius(SPAN_SQ - 1'b1);
      send_atom(atom_of(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
      send_atom(atom_of(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
      quiesce();

      write_radius(RADIUS_MAX);
      send_atom(atom_of(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
      send_atom(atom_of(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
      send_atom(atom_of(COORD_MAX, COORD_MIN, 0, 1'b1));
      quiesce();

      // fill the store, drop one plain atom and the closing atom
      for (int i = 0; i < MAX_ATOMS + 2; i++)
         send_atom(atom_of($urandom, $urandom, $urandom, i == MAX_ATOMS + 1));
      quiesce();

      for (int pace = 0; pace < 3; pace++) begin
         idle_pct = (pace == 0) ? 30 : (pace == 1) ? 84 : 0;
         for (int part = 0; part < 2; part++) begin
            quiesce();
            scale  = $urandom_range(0, COORD_W - 1);
            radius = RADIUS_W'(longint'($urandom_range(1, 3)) << (2 * scale))
                     + RADIUS_W'($urandom_range(0, 1 << scale));
            write_radius(radius);
            target = random_sent + RANDOM_ITEMS / 6;
            while (random_sent < target) begin
               send_random_molecule(idle_pct, scale);
               if ($urandom_range(19) == 0)
                  wait_drained();
            end
         end
      end
      quiesce();

      if (book.errors == 0 && book.expected_counts.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #150_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
